// File: rtl/core/depth_closest_point_tracker_defines.svh
// Assertion macros for the nearest-point tracker.
`ifndef DEPTH_CLOSEST_POINT_TRACKER_DEFINES_SVH
`define DEPTH_CLOSEST_POINT_TRACKER_DEFINES_SVH

// Check that cond holds at every clock edge out of reset.
`define DCPT_ASSERT_HOLDS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that cons holds at every clock edge where ante holds.
`define DCPT_ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/core/dcpt_pkg.sv
`default_nettype none
package dcpt_pkg;

  localparam int COORD_BITS = 16;

  localparam int MUL_A_W = 29;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

endpackage
`default_nettype wire

// File: rtl/core/dcpt_mul.sv
`default_nettype none
module dcpt_mul
  import dcpt_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic signed [MUL_A_W-1:0] a,
  input  wire logic signed [MUL_B_W-1:0] b,
  output logic signed [PROD_W-1:0]       prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule
`default_nettype wire

// File: rtl/core/depth_closest_point_tracker.sv
// Nearest-point tracker. Depth pixels arrive on the slave stream; a pixel inside the window
// (even column 120..518, even row 50..348, depth 1..5000 mm) is deprojected through a pinhole
// model, tilted into world axes and compared against the nearest point so far among points
// above 600 mm. A dropped pixel is taken in the accept state alone. A kept pixel passes the
// accept state, eight products through the single 29x25 registered multiplier, a state to
// form the height and one to update the nearest point; tready is low meanwhile. The pixel
// marked tlast then passes an emit state that loads the result register, waiting there while an
// earlier result still waits in that register; the loaded result then waits for the master side
// while the next pixel is taken. Configuration writes are taken at any time and must only be
// issued while the block is idle.
`default_nettype none
`include "depth_closest_point_tracker_defines.svh"
module depth_closest_point_tracker
  import dcpt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // pixel_col[9:0], pixel_row[19:10], depth_mm[35:20], zero fill
  input  wire logic [39:0] s_axis_tdata,
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // near_x_mm, near_fwd_mm, near_height_mm, point_found, door_open, zero fill
  output logic [((3 * COORD_BITS + 2 + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam int OUT_TDATA_W = ((3 * COORD_BITS + 2 + 7) / 8) * 8;
  localparam int DC_W    = 15;
  localparam int DEPTH_W = 13;
  localparam int TX_W    = 28;
  localparam int PT_W    = PROD_W - 28;
  localparam int R15_W   = PROD_W - 15;
  localparam int HGT_W   = R15_W + 1;

  localparam logic [9:0]  WIN_LEFT    = 10'd120;
  localparam logic [9:0]  WIN_RIGHT   = 10'd520;
  localparam logic [9:0]  WIN_TOP     = 10'd50;
  localparam logic [9:0]  WIN_BOTTOM  = 10'd350;
  localparam logic [15:0] DEPTH_LIMIT = 16'd5000;

  localparam logic signed [HGT_W-1:0]      MIN_HEIGHT = HGT_W'(600);
  localparam logic signed [COORD_BITS-1:0] DOOR_LIMIT = COORD_BITS'(200);
  localparam logic signed [COORD_BITS-1:0] COORD_MAX  = {1'b0, {(COORD_BITS - 1){1'b1}}};
  localparam logic signed [HGT_W-1:0]      SAT_HI     = HGT_W'(COORD_MAX);
  localparam logic signed [HGT_W-1:0]      SAT_LO     = -SAT_HI - HGT_W'(1);
  localparam logic signed [PROD_W-1:0]     HALF28     = PROD_W'(1) <<< 27;
  localparam logic signed [PROD_W-1:0]     HALF15     = PROD_W'(1) <<< 14;

  typedef enum logic [2:0] {
    REG_INV_FOCAL_X = 3'd0,
    REG_INV_FOCAL_Y = 3'd1,
    REG_CENTER_COL  = 3'd2,
    REG_CENTER_ROW  = 3'd3,
    REG_TILT_COS    = 3'd4,
    REG_TILT_SIN    = 3'd5,
    REG_MOUNT       = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_DC,
    ST_MUL_DR,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_ZS,
    ST_MUL_YC,
    ST_MUL_YS,
    ST_MUL_ZC,
    ST_HGT,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  function automatic logic signed [COORD_BITS-1:0] clamp_coord(
    input logic signed [HGT_W-1:0] v
  );
    logic signed [HGT_W-1:0] c;
    c = v;
    if (v > SAT_HI) c = SAT_HI;
    if (v < SAT_LO) c = SAT_LO;
    return c[COORD_BITS-1:0];
  endfunction

  function automatic logic signed [PT_W-1:0] round28(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] s;
    s = v + HALF28;
    return s[PROD_W-1:28];
  endfunction

  function automatic logic signed [R15_W-1:0] round15(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] s;
    s = v + HALF15;
    return s[PROD_W-1:15];
  endfunction

  logic [23:0]        inv_focal_x;
  logic [23:0]        inv_focal_y;
  logic [13:0]        center_col;
  logic [13:0]        center_row;
  logic signed [15:0] tilt_cos;
  logic signed [15:0] tilt_sin;
  logic [13:0]        mount_height;

  state_t                       state;
  logic signed [DC_W-1:0]       dc;
  logic signed [DC_W-1:0]       dr;
  logic [DEPTH_W-1:0]           depth;
  logic                         last;
  logic signed [TX_W-1:0]       tx;
  logic signed [TX_W-1:0]       ty;
  logic signed [PT_W-1:0]       px;
  logic signed [PT_W-1:0]       py;
  logic signed [PROD_W-1:0]     acc;
  logic signed [COORD_BITS-1:0] fwd;
  logic signed [HGT_W-1:0]      hgt;

  logic signed [COORD_BITS-1:0] best_x;
  logic signed [COORD_BITS-1:0] best_fwd;
  logic signed [COORD_BITS-1:0] best_height;
  logic                         seen_point;

  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_fwd;
  logic signed [COORD_BITS-1:0] out_hgt;
  logic                         out_found;
  logic                         out_door;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic [9:0]             in_col;
  logic [9:0]             in_row;
  logic [15:0]            in_depth;
  logic                   keep;
  logic signed [DC_W-1:0] dc_in;
  logic signed [DC_W-1:0] dr_in;
  logic                   in_fire;
  logic                   emit_ok;
  logic                   out_load;

  assign in_col   = s_axis_tdata[9:0];
  assign in_row   = s_axis_tdata[19:10];
  assign in_depth = s_axis_tdata[35:20];

  assign keep = (in_col >= WIN_LEFT) && (in_col < WIN_RIGHT) && !in_col[0] &&
                (in_row >= WIN_TOP) && (in_row < WIN_BOTTOM) && !in_row[0] &&
                (in_depth != 16'd0) && (in_depth <= DEPTH_LIMIT);

  assign dc_in = $signed({1'b0, in_col, 4'b0000}) - $signed({1'b0, center_col});
  assign dr_in = $signed({1'b0, in_row, 4'b0000}) - $signed({1'b0, center_row});

  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign emit_ok       = !m_axis_tvalid || m_axis_tready;
  assign out_load      = (state == ST_EMIT) && emit_ok;

  assign m_axis_tdata = OUT_TDATA_W'({out_door, out_found, out_hgt, out_fwd, out_x});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MUL_DC: begin
        mul_a = MUL_A_W'(dc);
        mul_b = MUL_B_W'($signed({1'b0, depth}));
      end
      ST_MUL_DR: begin
        mul_a = MUL_A_W'(dr);
        mul_b = MUL_B_W'($signed({1'b0, depth}));
      end
      ST_MUL_X: begin
        mul_a = MUL_A_W'(tx);
        mul_b = $signed({1'b0, inv_focal_x});
      end
      ST_MUL_Y: begin
        mul_a = MUL_A_W'(ty);
        mul_b = $signed({1'b0, inv_focal_y});
      end
      ST_MUL_ZS: begin
        mul_a = MUL_A_W'($signed({1'b0, depth}));
        mul_b = MUL_B_W'(tilt_sin);
      end
      ST_MUL_YC: begin
        mul_a = MUL_A_W'(py);
        mul_b = MUL_B_W'(tilt_cos);
      end
      ST_MUL_YS: begin
        mul_a = MUL_A_W'(py);
        mul_b = MUL_B_W'(tilt_sin);
      end
      ST_MUL_ZC: begin
        mul_a = MUL_A_W'($signed({1'b0, depth}));
        mul_b = MUL_B_W'(tilt_cos);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  dcpt_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_focal_x  <= 24'd44150;
      inv_focal_y  <= 24'd44150;
      center_col   <= 14'd5120;
      center_row   <= 14'd3840;
      tilt_cos     <= 16'sd31336;
      tilt_sin     <= 16'sd9581;
      mount_height <= 14'd2413;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INV_FOCAL_X: inv_focal_x  <= cfg_wdata;
        REG_INV_FOCAL_Y: inv_focal_y  <= cfg_wdata;
        REG_CENTER_COL:  center_col   <= cfg_wdata[13:0];
        REG_CENTER_ROW:  center_row   <= cfg_wdata[13:0];
        REG_TILT_COS:    tilt_cos     <= $signed(cfg_wdata[15:0]);
        REG_TILT_SIN:    tilt_sin     <= $signed(cfg_wdata[15:0]);
        REG_MOUNT:       mount_height <= cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      best_x        <= '0;
      best_fwd      <= COORD_MAX;
      best_height   <= '0;
      seen_point    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            dc    <= dc_in;
            dr    <= dr_in;
            depth <= in_depth[DEPTH_W-1:0];
            last  <= s_axis_tlast;
            if (keep) begin
              state <= ST_MUL_DC;
            end else if (s_axis_tlast) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_MUL_DC: state <= ST_MUL_DR;
        ST_MUL_DR: begin
          tx    <= prod[TX_W-1:0];
          state <= ST_MUL_X;
        end
        ST_MUL_X: begin
          ty    <= prod[TX_W-1:0];
          state <= ST_MUL_Y;
        end
        ST_MUL_Y: begin
          px    <= round28(prod);
          state <= ST_MUL_ZS;
        end
        ST_MUL_ZS: begin
          py    <= round28(prod);
          state <= ST_MUL_YC;
        end
        ST_MUL_YC: begin
          acc   <= prod;
          state <= ST_MUL_YS;
        end
        ST_MUL_YS: begin
          fwd   <= clamp_coord(HGT_W'(round15(acc - prod)));
          state <= ST_MUL_ZC;
        end
        ST_MUL_ZC: begin
          acc   <= -prod;
          state <= ST_HGT;
        end
        ST_HGT: begin
          hgt   <= HGT_W'(round15(acc - prod)) + $signed({{(HGT_W - 14){1'b0}}, mount_height});
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if ((hgt > MIN_HEIGHT) && (fwd < best_fwd)) begin
            best_x      <= clamp_coord(HGT_W'(px));
            best_fwd    <= fwd;
            best_height <= clamp_coord(hgt);
            seen_point  <= 1'b1;
          end
          state <= last ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (emit_ok) begin
            out_x         <= best_x;
            out_fwd       <= best_fwd;
            out_hgt       <= best_height;
            out_found     <= seen_point;
            out_door      <= (best_fwd < DOOR_LIMIT);
            best_fwd      <= COORD_MAX;
            seen_point    <= 1'b0;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `DCPT_ASSERT_IMPLIES(a_busy_not_ready, state != ST_IDLE, !s_axis_tready, "ready while busy")
  `DCPT_ASSERT_IMPLIES(a_seen_has_fwd, seen_point, best_fwd != COORD_MAX, "found point at max fwd")
  `DCPT_ASSERT_IMPLIES(a_door_needs_point, m_axis_tvalid && out_door, out_found, "door without point")

endmodule
`default_nettype wire

// File: tb/sv/dcpt_tb_pkg.sv
`timescale 1ns / 1ps
package dcpt_tb_pkg;
  import dcpt_pkg::*;

  typedef enum logic [2:0] {
    REG_INV_FOCAL_X  = 3'd0,
    REG_INV_FOCAL_Y  = 3'd1,
    REG_CENTER_COL   = 3'd2,
    REG_CENTER_ROW   = 3'd3,
    REG_TILT_COSINE  = 3'd4,
    REG_TILT_SINE    = 3'd5,
    REG_MOUNT_HEIGHT = 3'd6,
    REG_UNUSED       = 3'd7
  } cfg_reg_e;

  localparam int WIN_LEFT    = 120;
  localparam int WIN_RIGHT   = 520;
  localparam int WIN_TOP     = 50;
  localparam int WIN_BOTTOM  = 350;
  localparam int DEPTH_LIMIT = 5000;
  localparam int MIN_HEIGHT  = 600;
  localparam int DOOR_LIMIT  = 200;

  localparam longint COORD_MAX = (longint'(1) <<< (COORD_BITS - 1)) - 1;
  localparam longint COORD_MIN = -(longint'(1) <<< (COORD_BITS - 1));

  localparam int PIX_W  = 40;
  localparam int NEAR_W = 3 * COORD_BITS + 2;
  localparam int RES_W  = ((NEAR_W + 7) / 8) * 8;

  typedef struct packed {
    logic                           door;
    logic                           found;
    logic signed [COORD_BITS-1:0]   hgt;
    logic signed [COORD_BITS-1:0]   fwd;
    logic signed [COORD_BITS-1:0]   x;
  } near_result_t;

endpackage

// File: tb/sv/nearest_point_scoreboard.sv
`timescale 1ns / 1ps
module nearest_point_scoreboard
  import dcpt_pkg::*;
  import dcpt_tb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [23:0]      cfg_wdata,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [PIX_W-1:0] s_axis_tdata,
  input  logic             s_axis_tlast,
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [RES_W-1:0] m_axis_tdata,
  output int               mismatches,
  output int               outstanding
);

  longint inv_fx, inv_fy, ctr_col, ctr_row, tilt_cos, tilt_sin, mount_mm;
  longint near_x, near_fwd, near_hgt;
  bit     seen;
  near_result_t frame_reports[$];

  function automatic longint round_half_up(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sat_coord(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  task automatic track_pixel(input longint col, input longint row, input longint depth,
                             input bit last);
    longint dc, dr, px, py, fwd, hgt;
    near_result_t r;
    if (col >= WIN_LEFT && col < WIN_RIGHT && col % 2 == 0 &&
        row >= WIN_TOP && row < WIN_BOTTOM && row % 2 == 0 &&
        depth >= 1 && depth <= DEPTH_LIMIT) begin
      dc  = col * 16 - ctr_col;
      dr  = row * 16 - ctr_row;
      px  = round_half_up(dc * inv_fx * depth, 28);
      py  = round_half_up(dr * inv_fy * depth, 28);
      fwd = sat_coord(round_half_up(depth * tilt_sin - py * tilt_cos, 15));
      hgt = round_half_up(-py * tilt_sin - depth * tilt_cos, 15) + mount_mm;
      if (hgt > MIN_HEIGHT && fwd < near_fwd) begin
        near_x   = sat_coord(px);
        near_fwd = fwd;
        near_hgt = sat_coord(hgt);
        seen     = 1'b1;
      end
    end
    if (last) begin
      r.x     = near_x[COORD_BITS-1:0];
      r.fwd   = near_fwd[COORD_BITS-1:0];
      r.hgt   = near_hgt[COORD_BITS-1:0];
      r.found = seen;
      r.door  = near_fwd < DOOR_LIMIT;
      frame_reports = {frame_reports, r};
      near_fwd = COORD_MAX;
      seen     = 1'b0;
    end
  endtask

  always @(posedge clk) begin : watch
    near_result_t got, want;
    if (rst) begin
      inv_fx   = 44150;
      inv_fy   = 44150;
      ctr_col  = 5120;
      ctr_row  = 3840;
      tilt_cos = 31336;
      tilt_sin = 9581;
      mount_mm = 2413;
      near_x   = 0;
      near_fwd = COORD_MAX;
      near_hgt = 0;
      seen     = 1'b0;
      frame_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_INV_FOCAL_X:  inv_fx   = cfg_wdata;
          REG_INV_FOCAL_Y:  inv_fy   = cfg_wdata;
          REG_CENTER_COL:   ctr_col  = cfg_wdata[13:0];
          REG_CENTER_ROW:   ctr_row  = cfg_wdata[13:0];
          REG_TILT_COSINE:  tilt_cos = longint'($signed(cfg_wdata[15:0]));
          REG_TILT_SINE:    tilt_sin = longint'($signed(cfg_wdata[15:0]));
          REG_MOUNT_HEIGHT: mount_mm = cfg_wdata[13:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        track_pixel(s_axis_tdata[9:0], s_axis_tdata[19:10], s_axis_tdata[35:20],
                    s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        got = near_result_t'(m_axis_tdata[NEAR_W-1:0]);
        if (frame_reports.size() == 0) begin
          $error("result transaction with nothing expected");
          mismatches++;
        end else begin
          want = frame_reports.pop_front();
          if (got.x !== want.x) begin
            $error("near_x_mm expected %0d got %0d", want.x, got.x);
            mismatches++;
          end
          if (got.fwd !== want.fwd) begin
            $error("near_fwd_mm expected %0d got %0d", want.fwd, got.fwd);
            mismatches++;
          end
          if (got.hgt !== want.hgt) begin
            $error("near_height_mm expected %0d got %0d", want.hgt, got.hgt);
            mismatches++;
          end
          if (got.found !== want.found) begin
            $error("point_found expected %0d got %0d", want.found, got.found);
            mismatches++;
          end
          if (got.door !== want.door) begin
            $error("door_open expected %0d got %0d", want.door, got.door);
            mismatches++;
          end
        end
      end
    end
    outstanding = frame_reports.size();
  end

endmodule

// File: tb/sv/depth_closest_point_tracker_tb.sv
`timescale 1ns / 1ps
module depth_closest_point_tracker_tb;
  import dcpt_pkg::*;
  import dcpt_tb_pkg::*;

  localparam int ITEMS_PER_SEGMENT = 275;
  localparam int SEGMENTS          = 6;
  localparam int SETTLE_CYCLES     = 20;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [2:0]       cfg_index = '0;
  logic [23:0]      cfg_wdata = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [PIX_W-1:0] s_axis_tdata = '0;
  logic             s_axis_tlast = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [RES_W-1:0] m_axis_tdata;

  int fail_count;
  int results_outstanding;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  depth_closest_point_tracker dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  nearest_point_scoreboard scoreboard (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (fail_count),
    .outstanding   (results_outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    #5_000_000;
    $display("depth_closest_point_tracker verification failed");
    $finish;
  end

  task automatic send_pixel(input logic [9:0] col, input logic [9:0] row,
                            input logic [15:0] depth, input bit last);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, depth, row, col};
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (results_outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [23:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
  endtask

  task automatic apply_setting(input int seg);
    case (seg)
      1: begin
        write_reg(REG_INV_FOCAL_X, 24'hFFFFFF);
        write_reg(REG_INV_FOCAL_Y, 24'd0);
        write_reg(REG_CENTER_COL, 24'd0);
        write_reg(REG_CENTER_ROW, 24'd16383);
        write_reg(REG_TILT_COSINE, 24'h008000);
        write_reg(REG_TILT_SINE, 24'h007FFF);
        write_reg(REG_MOUNT_HEIGHT, 24'd16383);
        write_reg(REG_UNUSED, 24'($urandom()));
      end
      2: begin
        write_reg(REG_INV_FOCAL_X, 24'($urandom_range(60000, 30000)));
        write_reg(REG_INV_FOCAL_Y, 24'($urandom_range(60000, 30000)));
        write_reg(REG_CENTER_COL, 24'($urandom_range(6000, 4000)));
        write_reg(REG_CENTER_ROW, 24'($urandom_range(5000, 3000)));
        write_reg(REG_TILT_COSINE, 24'($urandom_range(32767, 28000)));
        write_reg(REG_TILT_SINE, 24'($urandom_range(15000, 5000)));
        write_reg(REG_MOUNT_HEIGHT, 24'($urandom_range(3500, 1500)));
      end
      3: begin
        write_reg(REG_INV_FOCAL_X, 24'd0);
        write_reg(REG_INV_FOCAL_Y, 24'hFFFFFF);
        write_reg(REG_CENTER_COL, 24'd16383);
        write_reg(REG_CENTER_ROW, 24'd0);
        write_reg(REG_TILT_COSINE, 24'h007FFF);
        write_reg(REG_TILT_SINE, 24'h008000);
        write_reg(REG_MOUNT_HEIGHT, 24'd0);
      end
      4: begin
        write_reg(REG_INV_FOCAL_X, 24'($urandom()));
        write_reg(REG_INV_FOCAL_Y, 24'($urandom()));
        write_reg(REG_CENTER_COL, 24'($urandom_range(16383)));
        write_reg(REG_CENTER_ROW, 24'($urandom_range(16383)));
        write_reg(REG_TILT_COSINE, 24'($urandom_range(65535)));
        write_reg(REG_TILT_SINE, 24'($urandom_range(65535)));
        write_reg(REG_MOUNT_HEIGHT, 24'($urandom_range(16383)));
        write_reg(REG_UNUSED, 24'($urandom()));
      end
      default: begin
        write_reg(REG_INV_FOCAL_X, 24'd44150);
        write_reg(REG_INV_FOCAL_Y, 24'd44150);
        write_reg(REG_CENTER_COL, 24'd5120);
        write_reg(REG_CENTER_ROW, 24'd3840);
        write_reg(REG_TILT_COSINE, 24'd31336);
        write_reg(REG_TILT_SINE, 24'd9581);
        write_reg(REG_MOUNT_HEIGHT, 24'd2413);
      end
    endcase
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic int edge_value(input int lo, input int hi);
    case ($urandom_range(7))
      0: return lo - 2;
      1: return lo - 1;
      2: return lo;
      3: return lo + 1;
      4: return hi - 2;
      5: return hi - 1;
      6: return hi;
      default: return hi + 1;
    endcase
  endfunction

  task automatic send_directed();
    send_pixel(10'd120, 10'd50, 16'd1, 1'b0);
    send_pixel(10'd518, 10'd348, 16'd5000, 1'b0);
    send_pixel(10'd320, 10'd240, 16'd1000, 1'b0);
    send_pixel(10'd119, 10'd200, 16'd1000, 1'b0);
    send_pixel(10'd520, 10'd200, 16'd1000, 1'b0);
    send_pixel(10'd321, 10'd200, 16'd1000, 1'b0);
    send_pixel(10'd320, 10'd49, 16'd1000, 1'b0);
    send_pixel(10'd320, 10'd350, 16'd1000, 1'b0);
    send_pixel(10'd320, 10'd241, 16'd1000, 1'b0);
    send_pixel(10'd320, 10'd200, 16'd0, 1'b0);
    send_pixel(10'd320, 10'd200, 16'd5001, 1'b0);
    send_pixel(10'd1023, 10'd1023, 16'hFFFF, 1'b0);
    send_pixel(10'd0, 10'd0, 16'd0, 1'b1);
    send_pixel(10'd0, 10'd0, 16'd0, 1'b1);
    send_pixel(10'd320, 10'd340, 16'd300, 1'b1);
    send_pixel(10'd200, 10'd300, 16'd800, 1'b0);
    send_pixel(10'd200, 10'd300, 16'd800, 1'b1);
    send_pixel(10'd400, 10'd100, 16'd4000, 1'b1);
  endtask

  initial begin : stimulus
    int count, flen, kind;
    logic [9:0]  col, row;
    logic [15:0] depth;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 2)
        0: begin
          tx_idle_pct = 18;
          rx_idle_pct = 58;
        end
        1: begin
          tx_idle_pct = 58;
          rx_idle_pct = 18;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      if (seg == 0) begin
        send_directed();
      end else begin
        drain();
        apply_setting(seg);
      end
      count = 0;
      while (count < ITEMS_PER_SEGMENT) begin
        flen = $urandom_range(12, 1);
        for (int i = 0; i < flen; i++) begin
          kind  = $urandom_range(99);
          col   = 10'(WIN_LEFT + 2 * $urandom_range((WIN_RIGHT - WIN_LEFT) / 2 - 1));
          row   = 10'(WIN_TOP + 2 * $urandom_range((WIN_BOTTOM - WIN_TOP) / 2 - 1));
          depth = $urandom_range(1) ? 16'($urandom_range(2000, 1))
                                    : 16'($urandom_range(DEPTH_LIMIT, 1));
          if (kind >= 90) begin
            col   = 10'($urandom());
            row   = 10'($urandom());
            depth = 16'($urandom());
          end else if (kind >= 72) begin
            if ($urandom_range(1)) col = 10'(edge_value(WIN_LEFT, WIN_RIGHT));
            if ($urandom_range(1)) row = 10'(edge_value(WIN_TOP, WIN_BOTTOM));
            if ($urandom_range(1)) depth = 16'(edge_value(1, DEPTH_LIMIT));
          end
          count++;
          send_pixel(col, row, depth, i == flen - 1);
        end
      end
    end
    drain();
    if (fail_count == 0)
      $display("depth_closest_point_tracker verification clean");
    else
      $display("depth_closest_point_tracker verification failed");
    $finish;
  end

endmodule
